// ----- rtl/core/hbcl_pkg.sv -----
// shared types and codes of the hashed block cache tag engine
// no dependencies; used by the controller, datapath, top level and checker
`default_nettype none

package hbcl_pkg;

   // action codes on the request channel
   localparam logic [1:0] ACT_GET     = 2'd0;
   localparam logic [1:0] ACT_RELEASE = 2'd1;
   localparam logic [1:0] ACT_PIN     = 2'd2;
   localparam logic [1:0] ACT_UNPIN   = 2'd3;

   // status codes on the response channel
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_FREE  = 2'd1;
   localparam logic [1:0] ST_UNDER    = 2'd2;
   localparam logic [1:0] ST_OVER     = 2'd3;

   // bucket reduction takes the block number a byte per step
   localparam int MOD_STEPS = 4;
   localparam int MOD_DIGIT = 8;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 16;

   typedef struct packed {
      logic init_wr;
      logic req_load;
      logic mod_step;
      logic scan_rd;
      logic ent_rd;
      logic get_commit;
      logic ent_commit;
   } cmd_type;

   typedef struct packed {
      logic is_get;
   } stat_type;

endpackage

`default_nettype wire

// ----- rtl/core/hbcl_datapath.sv -----
// datapath: entry memory, bucket reduction, scan trackers and result register
// depends on hbcl_pkg for command and status types and codes
`default_nettype none

module hbcl_datapath #(
   parameter int NUM_BUFFERS = 32,
   parameter int NUM_BUCKETS = 16,
   parameter int REF_BITS    = 8,
   parameter int IDX_W       = 5
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire hbcl_pkg::cmd_type                cmd,
   input  wire logic [IDX_W-1:0]                 addr,
   input  wire logic [hbcl_pkg::REQ_DATA_W-1:0]  req_data,
   output      hbcl_pkg::stat_type               stat,
   output      logic [hbcl_pkg::RSP_DATA_W-1:0]  rsp_data
);

   localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int RW    = BKT_W + 1;
   localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

   typedef struct packed {
      logic [7:0]          dev;
      logic [31:0]         blk;
      logic                valid;
      logic [REF_BITS-1:0] refs;
      logic [31:0]         stamp;
      logic [BKT_W-1:0]    bucket;
      logic [31:0]         order;
   } rec_type;

   rec_type mem [NUM_BUFFERS];
   rec_type rd_data_ff;

   // latched request
   logic [1:0]  act_ff,  act_in;
   logic [7:0]  dev_ff,  dev_in;
   logic [31:0] blk_ff,  blk_in;
   logic [4:0]  ent_ff,  ent_in;
   logic [31:0] now_ff,  now_in;

   logic [31:0]   shift_ff, shift_in;
   logic [RW-1:0] rem_ff,   rem_in;

   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] eidx_ff, eidx_in;

   logic             mfound_ff, mfound_in;
   logic [IDX_W-1:0] midx_ff,   midx_in;
   rec_type          mrec_ff,   mrec_in;

   logic             pfound_ff, pfound_in;
   logic [IDX_W-1:0] pidx_ff,   pidx_in;
   logic [RW-1:0]    pdist_ff,  pdist_in;
   logic [31:0]      pstamp_ff, pstamp_in;
   logic [31:0]      porder_ff, porder_in;

   logic [31:0]      ictr_ff,   ictr_in;
   logic [BKT_W-1:0] ibkt_ff,   ibkt_in;

   logic [4:0] rsp_ent_ff, rsp_ent_in;
   logic       rsp_hit_ff, rsp_hit_in;
   logic       rsp_rd_ff,  rsp_rd_in;
   logic [1:0] rsp_st_ff,  rsp_st_in;

   logic [BKT_W-1:0] home;
   logic [RW-1:0]    bkt_gap;
   logic             is_match, is_free, better;
   logic             ent_ok;
   logic [31:0]      ent32;
   logic [IDX_W-1:0] ent_addr;
   logic [IDX_W-1:0] rd_addr;
   logic             we;
   logic [IDX_W-1:0] wa;
   rec_type          wd;

   assign home     = rem_ff[BKT_W-1:0];
   assign ent32    = 32'(ent_ff);
   assign ent_ok   = ent32 < 32'(NUM_BUFFERS);
   assign ent_addr = ent_ok ? IDX_W'(ent32) : '0;
   assign rd_addr  = cmd.ent_rd ? ent_addr : addr;
   assign stat.is_get = (act_ff == hbcl_pkg::ACT_GET);

   // distance of the entry's bucket from home, going round cyclically
   always_comb begin
      if (rd_data_ff.bucket >= home) begin
         bkt_gap = {1'b0, rd_data_ff.bucket} - {1'b0, home};
      end else begin
         bkt_gap = {1'b0, rd_data_ff.bucket} + RW'(NUM_BUCKETS) - {1'b0, home};
      end
   end

   assign is_match = (rd_data_ff.bucket == home) && (rd_data_ff.dev == dev_ff)
                     && (rd_data_ff.blk == blk_ff);
   assign is_free  = (rd_data_ff.refs == '0);
   assign better   = !pfound_ff || (bkt_gap < pdist_ff)
                     || ((bkt_gap == pdist_ff) && ((rd_data_ff.stamp < pstamp_ff)
                     || ((rd_data_ff.stamp == pstamp_ff) && (rd_data_ff.order > porder_ff))));

   always_comb begin
      logic [RW-1:0] r;
      r        = rem_ff;
      act_in   = act_ff;
      dev_in   = dev_ff;
      blk_in   = blk_ff;
      ent_in   = ent_ff;
      now_in   = now_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      pend_in  = cmd.scan_rd;
      eidx_in  = addr;
      mfound_in = mfound_ff;
      midx_in   = midx_ff;
      mrec_in   = mrec_ff;
      pfound_in = pfound_ff;
      pidx_in   = pidx_ff;
      pdist_in  = pdist_ff;
      pstamp_in = pstamp_ff;
      porder_in = porder_ff;
      ictr_in   = ictr_ff;
      ibkt_in   = ibkt_ff;
      rsp_ent_in = rsp_ent_ff;
      rsp_hit_in = rsp_hit_ff;
      rsp_rd_in  = rsp_rd_ff;
      rsp_st_in  = rsp_st_ff;
      we = 1'b0;
      wa = addr;
      wd = rd_data_ff;

      if (cmd.req_load) begin
         act_in    = req_data[1:0];
         dev_in    = req_data[9:2];
         blk_in    = req_data[41:10];
         ent_in    = req_data[46:42];
         now_in    = req_data[78:47];
         shift_in  = req_data[41:10];
         rem_in    = '0;
         mfound_in = 1'b0;
         pfound_in = 1'b0;
      end

      // restoring reduction, one byte of the block number per step
      if (cmd.mod_step) begin
         for (int k = 0; k < hbcl_pkg::MOD_DIGIT; k++) begin
            r = {r[BKT_W-1:0], shift_ff[31-k]};
            if (r >= RW'(NUM_BUCKETS)) begin
               r = r - RW'(NUM_BUCKETS);
            end
         end
         rem_in   = r;
         shift_in = {shift_ff[31-hbcl_pkg::MOD_DIGIT:0], {hbcl_pkg::MOD_DIGIT{1'b0}}};
      end

      if (pend_ff) begin
         if (is_match && (!mfound_ff || (rd_data_ff.order > mrec_ff.order))) begin
            mfound_in = 1'b1;
            midx_in   = eidx_ff;
            mrec_in   = rd_data_ff;
         end
         if (is_free && better) begin
            pfound_in = 1'b1;
            pidx_in   = eidx_ff;
            pdist_in  = bkt_gap;
            pstamp_in = rd_data_ff.stamp;
            porder_in = rd_data_ff.order;
         end
      end

      if (cmd.init_wr) begin
         we = 1'b1;
         wd = '{dev: '0, blk: '0, valid: 1'b0, refs: '0, stamp: '0,
                bucket: ibkt_ff, order: 32'(addr)};
         ibkt_in = (32'(ibkt_ff) == NUM_BUCKETS - 1) ? '0 : ibkt_ff + 1'b1;
      end

      if (cmd.get_commit) begin
         rsp_rd_in = 1'b0;
         rsp_st_in = hbcl_pkg::ST_OK;
         if (mfound_ff) begin
            rsp_ent_in = 5'(8'(midx_ff));
            rsp_hit_in = 1'b1;
            if (mrec_ff.refs == REF_MAX) begin
               rsp_st_in = hbcl_pkg::ST_OVER;
            end else begin
               we = 1'b1;
               wa = midx_ff;
               wd = mrec_ff;
               wd.refs  = mrec_ff.refs + 1'b1;
               wd.stamp = now_ff;
               wd.valid = 1'b1;
               rsp_rd_in = !mrec_ff.valid;
            end
         end else if (pfound_ff) begin
            rsp_ent_in = 5'(8'(pidx_ff));
            rsp_hit_in = 1'b0;
            rsp_rd_in  = 1'b1;
            we = 1'b1;
            wa = pidx_ff;
            wd = '{dev: dev_ff, blk: blk_ff, valid: 1'b1, refs: REF_BITS'(1),
                   stamp: now_ff, bucket: home, order: ictr_ff};
            ictr_in = ictr_ff + 32'd1;
         end else begin
            rsp_ent_in = '0;
            rsp_hit_in = 1'b0;
            rsp_st_in  = hbcl_pkg::ST_NO_FREE;
         end
      end

      if (cmd.ent_commit) begin
         rsp_ent_in = ent_ff;
         rsp_hit_in = 1'b0;
         rsp_rd_in  = 1'b0;
         rsp_st_in  = hbcl_pkg::ST_OK;
         wa = ent_addr;
         wd = rd_data_ff;
         if (!ent_ok) begin
            rsp_st_in = hbcl_pkg::ST_NO_FREE;
         end else if (act_ff == hbcl_pkg::ACT_PIN) begin
            if (rd_data_ff.refs == REF_MAX) begin
               rsp_st_in = hbcl_pkg::ST_OVER;
            end else begin
               we = 1'b1;
               wd.refs = rd_data_ff.refs + 1'b1;
            end
         end else if (rd_data_ff.refs == '0) begin
            rsp_st_in = hbcl_pkg::ST_UNDER;
         end else begin
            we = 1'b1;
            wd.refs = rd_data_ff.refs - 1'b1;
            if (act_ff == hbcl_pkg::ACT_RELEASE) begin
               wd.stamp = now_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (cmd.scan_rd || cmd.ent_rd) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         ictr_ff <= 32'(NUM_BUFFERS);
         ibkt_ff <= '0;
      end else begin
         pend_ff <= pend_in;
         ictr_ff <= ictr_in;
         ibkt_ff <= ibkt_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      dev_ff    <= dev_in;
      blk_ff    <= blk_in;
      ent_ff    <= ent_in;
      now_ff    <= now_in;
      shift_ff  <= shift_in;
      rem_ff    <= rem_in;
      eidx_ff   <= eidx_in;
      mfound_ff <= mfound_in;
      midx_ff   <= midx_in;
      mrec_ff   <= mrec_in;
      pfound_ff <= pfound_in;
      pidx_ff   <= pidx_in;
      pdist_ff  <= pdist_in;
      pstamp_ff <= pstamp_in;
      porder_ff <= porder_in;
      rsp_ent_ff <= rsp_ent_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_rd_ff  <= rsp_rd_in;
      rsp_st_ff  <= rsp_st_in;
   end

   assign rsp_data = {7'b0, rsp_st_ff, rsp_rd_ff, rsp_hit_ff, rsp_ent_ff};

endmodule

`default_nettype wire

// ----- rtl/core/hbcl_controller.sv -----
// controller: sequencing of clearing pass, get scan and entry updates, response handshake
// depends on hbcl_pkg for command and status types
`default_nettype none

module hbcl_controller #(
   parameter int NUM_BUFFERS = 32,
   parameter int IDX_W       = 5
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output      logic               req_tready,
   output      logic               rsp_tvalid,
   input  wire logic               rsp_tready,
   input  wire hbcl_pkg::stat_type stat,
   output      hbcl_pkg::cmd_type  cmd,
   output      logic [IDX_W-1:0]   addr
);

   localparam int CNT_W = (IDX_W > 2) ? IDX_W : 2;

   localparam logic [3:0] S_INIT    = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_DISP    = 4'd2;
   localparam logic [3:0] S_MOD     = 4'd3;
   localparam logic [3:0] S_SCAN    = 4'd4;
   localparam logic [3:0] S_DRAIN   = 4'd5;
   localparam logic [3:0] S_GCOMMIT = 4'd6;
   localparam logic [3:0] S_ERD     = 4'd7;
   localparam logic [3:0] S_ECOMMIT = 4'd8;

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff,   cnt_in;
   logic             rvalid_ff, rvalid_in;
   logic             out_free;
   logic             last_entry;

   assign out_free   = !rvalid_ff || rsp_tready;
   assign last_entry = (cnt_ff == CNT_W'(NUM_BUFFERS - 1));
   assign addr       = cnt_ff[IDX_W-1:0];
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rvalid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_INIT: begin
            cmd.init_wr = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (last_entry) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.req_load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            cnt_in   = '0;
            state_in = stat.is_get ? S_MOD : S_ERD;
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(hbcl_pkg::MOD_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (last_entry) begin
               cnt_in   = '0;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_GCOMMIT;
         end
         S_GCOMMIT: begin
            if (out_free) begin
               cmd.get_commit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_ERD: begin
            cmd.ent_rd = 1'b1;
            state_in = S_ECOMMIT;
         end
         S_ECOMMIT: begin
            if (out_free) begin
               cmd.ent_commit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
            cnt_in   = '0;
         end
      endcase
   end

   always_comb begin
      rvalid_in = rvalid_ff && !rsp_tready;
      if (cmd.get_commit || cmd.ent_commit) begin
         rvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_INIT;
         cnt_ff    <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         rvalid_ff <= rvalid_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/hashed_block_cache_lru.sv -----
// Hashed block buffer cache tag engine.
// Request channel (req_*) carries one action per item: get, release, pin or unpin.
// Response channel (rsp_*) returns exactly one item per request, in order.
// A get reduces the block number to its home bucket, then reads every
// entry of the entry memory once, one per cycle, tracking the newest tag match in
// the home bucket and the best unreferenced victim by bucket distance, stamp and
// insert order. No new request is accepted until a get has committed its result;
// the entry memory has a single read port.
// Release, pin and unpin read and rewrite one entry, and likewise block new requests
// until their result is committed.
// After reset a clearing pass writes every entry of the entry memory;
// req_tready stays low during it.
// The response register holds its item while rsp_tready is low; a new request is
// still accepted, and its result waits until the held item has been taken.
// Depends on hbcl_pkg, hbcl_controller and hbcl_datapath.
`default_nettype none

module hashed_block_cache_lru #(
   parameter int NUM_BUFFERS = 32,
   parameter int NUM_BUCKETS = 16,
   parameter int REF_BITS    = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // action[1:0], device[9:2], block_number[41:10], entry[46:42], now[78:47], zero pad
   input  wire logic [79:0] req_tdata,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // entry_out[4:0], hit[5], need_read[6], status[8:7], zero pad
   output      logic [15:0] rsp_tdata
);

   localparam int IDX_W = $clog2(NUM_BUFFERS);

   hbcl_pkg::cmd_type  cmd;
   hbcl_pkg::stat_type stat;
   logic [IDX_W-1:0]   addr;

   hbcl_controller #(
      .NUM_BUFFERS(NUM_BUFFERS),
      .IDX_W      (IDX_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .stat      (stat),
      .cmd       (cmd),
      .addr      (addr)
   );

   hbcl_datapath #(
      .NUM_BUFFERS(NUM_BUFFERS),
      .NUM_BUCKETS(NUM_BUCKETS),
      .REF_BITS   (REF_BITS),
      .IDX_W      (IDX_W)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .addr    (addr),
      .req_data(req_tdata),
      .stat    (stat),
      .rsp_data(rsp_tdata)
   );

endmodule

`default_nettype wire

// ----- rtl/core/hbcl_checker.sv -----
// port-level checks of the cache tag engine, bound to the top level
// depends on hbcl_pkg for status codes
`default_nettype none

module hbcl_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [79:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);

   // a stalled response item stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // clearing pass keeps the request side closed right after reset
   a_reset_closed: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("channels open right after reset");

   // a refused item carries neither hit nor read request
   a_nofree_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[8:7] == hbcl_pkg::ST_NO_FREE) |-> !rsp_tdata[5] && !rsp_tdata[6])
      else $error("no-free response with hit or need_read");

   // need_read only on a successful get
   a_read_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[6] |-> (rsp_tdata[8:7] == hbcl_pkg::ST_OK))
      else $error("need_read with error status");

   // a hit can only fail by count overflow
   a_hit_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[5] |->
         (rsp_tdata[8:7] == hbcl_pkg::ST_OK) || (rsp_tdata[8:7] == hbcl_pkg::ST_OVER))
      else $error("hit with unexpected status");

endmodule

bind hashed_block_cache_lru hbcl_checker u_hbcl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tdata (req_tdata),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

`default_nettype wire

// ----- verif/hashed_block_cache_lru_tb.sv -----
// self-checking bench for the hashed block cache tag engine
// holds its own predictor of the tag store; depends on hbcl_pkg and hashed_block_cache_lru
`timescale 1ns / 100ps

module hashed_block_cache_lru_tb;

   localparam int NBUF = 32;
   localparam int NBKT = 16;
   localparam logic [7:0] REF_LIMIT = 8'hFF;
   localparam int STALL_LIMIT = 20000;

   // last field in the lowest bits, as on req_tdata
   typedef struct packed {
      logic [31:0] now;
      logic [4:0]  entry;
      logic [31:0] block_number;
      logic [7:0]  device;
      logic [1:0]  action;
   } cache_req_type;

   // last field in the lowest bits, as on rsp_tdata
   typedef struct packed {
      logic [1:0] status;
      logic       need_read;
      logic       hit;
      logic [4:0] entry_out;
   } cache_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   hashed_block_cache_lru u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #1 clock = ~clock;

   // shadow copy of the tag store
   logic [7:0]  sh_dev [NBUF];
   logic [31:0] sh_blk [NBUF];
   logic        sh_valid [NBUF];
   logic [7:0]  sh_refs [NBUF];
   logic [31:0] sh_stamp [NBUF];
   logic [3:0]  sh_bucket [NBUF];
   logic [31:0] sh_order [NBUF];
   logic [31:0] sh_next_order;

   cache_req_type pending_reqs[$];
   cache_rsp_type expected_rsps[$];
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  mismatches = 0;
   int  idle_cycles = 0;
   logic stim_done = 1'b0;
   logic timed_out = 1'b0;
   // item taken at the last rising edge
   logic req_taken = 1'b0;

   function automatic cache_rsp_type lookup_and_update(cache_req_type r);
      cache_rsp_type res;
      logic [3:0] home;
      int found;
      int pick;
      logic [3:0] bk;
      res = '0;
      if (r.action == hbcl_pkg::ACT_GET) begin
         home = r.block_number[3:0];
         found = -1;
         for (int i = 0; i < NBUF; i++)
            if (sh_bucket[i] == home && sh_dev[i] == r.device && sh_blk[i] == r.block_number)
               if (found < 0 || sh_order[i] > sh_order[found]) found = i;
         if (found >= 0) begin
            res.entry_out = found[4:0];
            res.hit = 1'b1;
            if (sh_refs[found] >= REF_LIMIT) begin
               res.status = hbcl_pkg::ST_OVER;
            end else begin
               sh_refs[found]++;
               sh_stamp[found] = r.now;
               res.need_read = ~sh_valid[found];
               sh_valid[found] = 1'b1;
               res.status = hbcl_pkg::ST_OK;
            end
            return res;
         end
         for (int c = 0; c < NBKT; c++) begin
            bk = home + c[3:0];
            pick = -1;
            for (int i = 0; i < NBUF; i++) begin
               if (sh_bucket[i] != bk || sh_refs[i] != 0) continue;
               if (pick < 0 || sh_stamp[i] < sh_stamp[pick] ||
                   (sh_stamp[i] == sh_stamp[pick] && sh_order[i] > sh_order[pick]))
                  pick = i;
            end
            if (pick >= 0) begin
               sh_bucket[pick] = home;
               sh_order[pick] = sh_next_order;
               sh_next_order++;
               sh_dev[pick] = r.device;
               sh_blk[pick] = r.block_number;
               sh_refs[pick] = 8'd1;
               sh_stamp[pick] = r.now;
               sh_valid[pick] = 1'b1;
               res.entry_out = pick[4:0];
               res.need_read = 1'b1;
               res.status = hbcl_pkg::ST_OK;
               return res;
            end
         end
         res.status = hbcl_pkg::ST_NO_FREE;
         return res;
      end
      res.entry_out = r.entry;
      if (r.action == hbcl_pkg::ACT_PIN) begin
         if (sh_refs[r.entry] >= REF_LIMIT) res.status = hbcl_pkg::ST_OVER;
         else sh_refs[r.entry]++;
      end else if (sh_refs[r.entry] == 0) begin
         res.status = hbcl_pkg::ST_UNDER;
      end else begin
         sh_refs[r.entry]--;
         if (r.action == hbcl_pkg::ACT_RELEASE) sh_stamp[r.entry] = r.now;
      end
      return res;
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tdata <= {1'b0, pending_reqs.pop_front()};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor, predictor and watchdog
   always @(posedge clock) begin
      cache_rsp_type got;
      cache_rsp_type want;
      if (!reset) begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready)
            expected_rsps.push_back(lookup_and_update(cache_req_type'(req_tdata[78:0])));
         if (rsp_tvalid && rsp_tready) begin
            got = cache_rsp_type'(rsp_tdata[8:0]);
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected item: %h", got);
            end else begin
               want = expected_rsps.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: exp entry=%0d hit=%0d rd=%0d st=%0d",
                               " got entry=%0d hit=%0d rd=%0d st=%0d"},
                              want.entry_out, want.hit, want.need_read, want.status,
                              got.entry_out, got.hit, got.need_read, got.status);
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) timed_out <= 1'b1;
      end
   end

   function automatic cache_req_type make_req(logic [1:0] act, logic [7:0] dev,
                                              logic [31:0] blk, logic [4:0] ent,
                                              logic [31:0] tick);
      cache_req_type r;
      r.action = act;
      r.device = dev;
      r.block_number = blk;
      r.entry = ent;
      r.now = tick;
      return r;
   endfunction

   task automatic run_phase(int idle_pct, int stall_pct, int count);
      logic [31:0] tick;
      logic [31:0] blocks [8];
      logic [7:0]  devs [2];
      int sel;
      tick = $urandom;
      for (int i = 0; i < 8; i++) blocks[i] = (i < 2) ? $urandom : $urandom_range(40);
      devs[0] = 8'($urandom);
      devs[1] = 8'($urandom);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         tick = tick + $urandom_range(3);
         sel = $urandom_range(99);
         // gets of a small working set are the commonest action, so hits, evictions and full buckets occur
         if (sel < 45)
            pending_reqs.push_back(make_req(hbcl_pkg::ACT_GET, devs[$urandom_range(1)],
               (sel < 3) ? $urandom : blocks[$urandom_range(7)], 5'($urandom), tick));
         else if (sel < 75)
            pending_reqs.push_back(make_req(hbcl_pkg::ACT_RELEASE, 8'($urandom), $urandom,
                                            5'($urandom), tick));
         else if (sel < 88)
            pending_reqs.push_back(make_req(hbcl_pkg::ACT_PIN, 8'($urandom), $urandom,
                                            5'($urandom), tick));
         else
            pending_reqs.push_back(make_req(hbcl_pkg::ACT_UNPIN, 8'($urandom), $urandom,
                                            5'($urandom), tick));
      end
      wait (pending_reqs.size() == 0 || timed_out);
      wait (expected_rsps.size() == 0 || timed_out);
   endtask

   initial begin
      for (int i = 0; i < NBUF; i++) begin
         sh_dev[i] = '0;
         sh_blk[i] = '0;
         sh_valid[i] = 1'b0;
         sh_refs[i] = '0;
         sh_stamp[i] = '0;
         sh_bucket[i] = 4'(i % NBKT);
         sh_order[i] = 32'(i);
      end
      sh_next_order = 32'(NBUF);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: unknown entry data, release at zero, extreme fields, hit after miss
      pending_reqs.push_back(make_req(hbcl_pkg::ACT_GET, 8'd0, 32'd0, 5'd0, 32'd0));
      pending_reqs.push_back(make_req(hbcl_pkg::ACT_GET, 8'd0, 32'd0, 5'd0, 32'd5));
      pending_reqs.push_back(make_req(hbcl_pkg::ACT_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31,
                                      32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(hbcl_pkg::ACT_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd31,
                                      32'd7));
      pending_reqs.push_back(make_req(hbcl_pkg::ACT_UNPIN, 8'd0, 32'd0, 5'd31, 32'd0));
      pending_reqs.push_back(make_req(hbcl_pkg::ACT_RELEASE, 8'd0, 32'd0, 5'd5, 32'd0));
      pending_reqs.push_back(make_req(hbcl_pkg::ACT_PIN, 8'd0, 32'd0, 5'd5, 32'd1));
      pending_reqs.push_back(make_req(hbcl_pkg::ACT_UNPIN, 8'd0, 32'd0, 5'd5, 32'd1));
      pending_reqs.push_back(make_req(hbcl_pkg::ACT_RELEASE, 8'd0, 32'd0, 5'd0, 32'd9));
      pending_reqs.push_back(make_req(hbcl_pkg::ACT_RELEASE, 8'd0, 32'd0, 5'd0, 32'd9));
      // fill every buffer so a further get finds no free one
      for (int i = 0; i < NBUF; i++)
         pending_reqs.push_back(make_req(hbcl_pkg::ACT_PIN, 8'd0, 32'd0, i[4:0], 32'd0));
      pending_reqs.push_back(make_req(hbcl_pkg::ACT_GET, 8'd3, 32'd77, 5'd0, 32'd20));
      // entry 16 holds device 0 block 0; pin it to the count limit, then a hit overflows
      for (int i = 0; i < 260; i++)
         pending_reqs.push_back(make_req(hbcl_pkg::ACT_PIN, 8'd0, 32'd0, 5'd16, 32'd0));
      pending_reqs.push_back(make_req(hbcl_pkg::ACT_GET, 8'd0, 32'd0, 5'd0, 32'd30));
      for (int i = 0; i < 300; i++)
         pending_reqs.push_back(make_req(hbcl_pkg::ACT_UNPIN, 8'd0, 32'd0, 5'd16, 32'd0));
      for (int i = 0; i < NBUF; i++)
         pending_reqs.push_back(make_req(hbcl_pkg::ACT_UNPIN, 8'd0, 32'd0, i[4:0], 32'd0));
      wait (pending_reqs.size() == 0 || timed_out);
      wait (expected_rsps.size() == 0 || timed_out);

      run_phase(0, 0, 330);
      run_phase(84, 0, 330);
      run_phase(0, 84, 330);
      run_phase(33, 33, 324);
      repeat (100) @(posedge clock);

      if (timed_out || mismatches != 0 || expected_rsps.size() != 0) begin
         $display("status: fail");
      end else begin
         $display("status: pass");
      end
      $finish;
   end

endmodule
